### rtl/text_cursor_glyph_renderer_top_macros.svh
// ----------------------------------------------------------------------------
// Text cursor glyph renderer - assertion macros
// Shared property templates for the renderer's internal checks.
// ----------------------------------------------------------------------------
`ifndef TEXT_CURSOR_GLYPH_RENDERER_TOP_MACROS_SVH
`define TEXT_CURSOR_GLYPH_RENDERER_TOP_MACROS_SVH

// condition must hold at every clock edge out of reset
`define TCGR_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TCGR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tcgr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text cursor glyph renderer - package
// Shared types, register indexes and the 5x7 font table.
// ----------------------------------------------------------------------------
package tcgr_pkg;

    localparam int GLYPH_COLUMNS = 5;
    localparam int BYTE_W        = 8;
    localparam int COORD_W       = 10;
    localparam int COLOR_W       = 16;
    localparam int OFFSET_W      = 8;
    localparam int CURSOR_W      = 6;
    localparam int CODE_W        = 8;
    localparam int SLOT_W        = 7;
    localparam int COL_IDX_W     = 3;
    localparam int ROW_IDX_W     = 3;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int CODE_COUNT    = 96;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [CODE_W-1:0] FIRST_CODE = 8'd32;

    localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_H_OFFSET   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_V_OFFSET   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS       = 3'd5;

    localparam logic KIND_DRAW   = 1'b0;
    localparam logic KIND_CURSOR = 1'b1;

    typedef logic [0:GLYPH_COLUMNS-1][BYTE_W-1:0] t_glyph;

    typedef struct packed {
        logic [COLOR_W-1:0]  foreground_color;
        logic [COLOR_W-1:0]  background_color;
        logic [OFFSET_W-1:0] horizontal_offset;
        logic [OFFSET_W-1:0] vertical_offset;
        logic [CURSOR_W-1:0] columns_per_row;
        logic [CURSOR_W-1:0] rows_per_screen;
    } t_cfg;

    typedef struct packed {
        logic [COORD_W-1:0] base_x;
        logic [COORD_W-1:0] base_y;
        t_glyph             glyph;
    } t_cmd;

    localparam t_glyph FONT_ROM [0:CODE_COUNT-1] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
        40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
        40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
        40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h081454543C,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h007F102844,
        40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
        40'h00007F0000, 40'h0041360800, 40'h08082A1C08, 40'h081C2A0808
    };

endpackage
`default_nettype wire

### rtl/tcgr_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text cursor glyph renderer - front end
// Holds the cursor, looks up the glyph and forms the cell origin of each draw.
// ----------------------------------------------------------------------------
module tcgr_front #(
    parameter int CELL_WIDTH  = 6,
    parameter int CELL_HEIGHT = 8
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_accept,
    input  wire                         i_kind,
    input  wire [tcgr_pkg::CODE_W-1:0]  i_char_code,
    input  wire [tcgr_pkg::CURSOR_W-1:0] i_new_column,
    input  wire [tcgr_pkg::CURSOR_W-1:0] i_new_row,
    input  wire tcgr_pkg::t_cfg         i_cfg,
    output logic                        o_q_wr,
    output tcgr_pkg::t_cmd              o_q_cmd
);
    import tcgr_pkg::*;

    logic [CURSOR_W-1:0] r_col;
    logic [CURSOR_W-1:0] r_row;
    logic [CURSOR_W-1:0] n_col;
    logic [CURSOR_W-1:0] n_row;
    logic [CURSOR_W:0]   w_col_inc;
    logic [CURSOR_W:0]   w_row_inc;
    logic [SLOT_W-1:0]   w_slot;
    logic                w_in_font;

    assign w_in_font = (i_char_code >= FIRST_CODE) && !i_char_code[CODE_W-1];
    assign w_slot    = w_in_font ? SLOT_W'(i_char_code - FIRST_CODE) : '0;

    assign o_q_wr              = i_accept && (i_kind == KIND_DRAW);
    assign o_q_cmd.glyph       = FONT_ROM[w_slot];
    assign o_q_cmd.base_x      = COORD_W'(r_col * CELL_WIDTH) +
                                 COORD_W'(i_cfg.horizontal_offset);
    assign o_q_cmd.base_y      = COORD_W'(r_row * CELL_HEIGHT) +
                                 COORD_W'(i_cfg.vertical_offset);

    always_comb begin
        w_col_inc = {1'b0, r_col} + 1'b1;
        w_row_inc = {1'b0, r_row};
        if (w_col_inc >= {1'b0, i_cfg.columns_per_row}) begin
            w_col_inc = '0;
            w_row_inc = {1'b0, r_row} + 1'b1;
        end
        if (w_row_inc >= {1'b0, i_cfg.rows_per_screen}) begin
            w_row_inc = '0;
        end
        n_col = w_col_inc[CURSOR_W-1:0];
        n_row = w_row_inc[CURSOR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            if (i_kind == KIND_CURSOR) begin
                r_col <= i_new_column;
                r_row <= i_new_row;
            end else begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

endmodule
`default_nettype wire

### rtl/tcgr_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text cursor glyph renderer - command queue
// Short FIFO of draw commands between the front end and the pixel generator.
// ----------------------------------------------------------------------------
module tcgr_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_wr,
    input  wire tcgr_pkg::t_cmd  i_cmd,
    output logic                 o_full,
    input  wire                  i_rd,
    output tcgr_pkg::t_cmd       o_cmd,
    output logic                 o_empty
);
    import tcgr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [0:QUEUE_DEPTH-1];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + 1'b1;
            end else if (i_rd && !i_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

### rtl/tcgr_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text cursor glyph renderer - pixel generator
// Walks each glyph row by row and emits one pixel per cycle into an output
// register while that register is empty or being popped.
// ----------------------------------------------------------------------------
module tcgr_back #(
    parameter int GLYPH_ROWS = 7
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire tcgr_pkg::t_cfg          i_cfg,
    input  wire tcgr_pkg::t_cmd          i_q_cmd,
    input  wire                          i_q_empty,
    output logic                         o_q_rd,
    input  wire                          i_pop,
    output logic                         o_empty,
    output logic [tcgr_pkg::COORD_W-1:0] o_pixel_x,
    output logic [tcgr_pkg::COORD_W-1:0] o_pixel_y,
    output logic [tcgr_pkg::COLOR_W-1:0] o_pixel_color,
    output logic                         o_last_pixel
);
    import tcgr_pkg::*;

    localparam logic [COL_IDX_W-1:0] COL_LAST = COL_IDX_W'(GLYPH_COLUMNS - 1);
    localparam logic [ROW_IDX_W-1:0] ROW_LAST = ROW_IDX_W'(GLYPH_ROWS - 1);

    logic                 r_busy;
    logic [COL_IDX_W-1:0] r_gc;
    logic [ROW_IDX_W-1:0] r_gr;
    logic [COORD_W-1:0]   r_bx;
    logic [COORD_W-1:0]   r_by;
    t_glyph               r_glyph;
    logic                 r_out_valid;
    logic [COORD_W-1:0]   r_x;
    logic [COORD_W-1:0]   r_y;
    logic [COLOR_W-1:0]   r_color;
    logic                 r_last;

    logic w_out_ready;
    logic w_step;
    logic w_glyph_done;
    logic w_load;

    assign w_out_ready  = !r_out_valid || i_pop;
    assign w_step       = r_busy && w_out_ready;
    assign w_glyph_done = (r_gc == COL_LAST) && (r_gr == ROW_LAST);
    assign w_load       = !i_q_empty && (!r_busy || (w_step && w_glyph_done));
    assign o_q_rd       = w_load;

    assign o_empty       = !r_out_valid;
    assign o_pixel_x     = r_x;
    assign o_pixel_y     = r_y;
    assign o_pixel_color = r_color;
    assign o_last_pixel  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_gc        <= '0;
            r_gr        <= '0;
        end else begin
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            if (w_load) begin
                r_busy <= 1'b1;
                r_gc   <= '0;
                r_gr   <= '0;
            end else if (w_step) begin
                if (w_glyph_done) begin
                    r_busy <= 1'b0;
                end
                if (r_gc == COL_LAST) begin
                    r_gc <= '0;
                    r_gr <= r_gr + 1'b1;
                end else begin
                    r_gc <= r_gc + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_bx    <= i_q_cmd.base_x;
            r_by    <= i_q_cmd.base_y;
            r_glyph <= i_q_cmd.glyph;
        end
        if (w_step) begin
            r_x     <= r_bx + COORD_W'(r_gc);
            r_y     <= r_by + COORD_W'(r_gr);
            r_color <= r_glyph[r_gc][r_gr] ? i_cfg.foreground_color
                                           : i_cfg.background_color;
            r_last  <= w_glyph_done;
        end
    end

endmodule
`default_nettype wire

### rtl/text_cursor_glyph_renderer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text cursor glyph renderer - top level
// Character generator with cursor: draws 5-column font glyphs as pixel
// transactions at the cursor cell and advances the cursor.
// ----------------------------------------------------------------------------
// A draw transaction yields 5 x GLYPH_ROWS pixel transactions (35 by default),
// one per cycle from the pixel generator while pop stays high; the generator
// loads another queued draw as it emits the last pixel of the current one.
// A set-cursor transaction yields no pixels. The front end takes each
// transaction in the cycle that push is high and full is low, and holds up to
// two draws in the command queue ahead of the generator; full reflects that
// queue alone. Codes outside 32..127 draw as space. Configuration writes are
// always accepted and must be made only while the block is idle.
// ----------------------------------------------------------------------------
module text_cursor_glyph_renderer_top #(
    parameter int GLYPH_ROWS  = 7,
    parameter int CELL_WIDTH  = 6,
    parameter int CELL_HEIGHT = 8
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             push,
    output logic                            full,
    input  wire                             i_kind,
    input  wire [tcgr_pkg::CODE_W-1:0]      i_char_code,
    input  wire [tcgr_pkg::CURSOR_W-1:0]    i_new_column,
    input  wire [tcgr_pkg::CURSOR_W-1:0]    i_new_row,
    output logic                            empty,
    input  wire                             pop,
    output logic [tcgr_pkg::COORD_W-1:0]    o_pixel_x,
    output logic [tcgr_pkg::COORD_W-1:0]    o_pixel_y,
    output logic [tcgr_pkg::COLOR_W-1:0]    o_pixel_color,
    output logic                            o_last_pixel,
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire [tcgr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [tcgr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import tcgr_pkg::*;

`include "text_cursor_glyph_renderer_top_macros.svh"

    t_cfg r_cfg;
    t_cmd w_q_wr_cmd;
    t_cmd w_q_rd_cmd;
    logic w_accept;
    logic w_q_wr;
    logic w_q_rd;
    logic w_q_full;
    logic w_q_empty;

    assign o_cfg_ready = 1'b1;
    assign full        = w_q_full;
    assign w_accept    = push && !w_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.foreground_color  <= 16'hFFFF;
            r_cfg.background_color  <= '0;
            r_cfg.horizontal_offset <= '0;
            r_cfg.vertical_offset   <= '0;
            r_cfg.columns_per_row   <= 6'd21;
            r_cfg.rows_per_screen   <= 6'd20;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_FOREGROUND: r_cfg.foreground_color  <= i_cfg_data;
                CFG_BACKGROUND: r_cfg.background_color  <= i_cfg_data;
                CFG_H_OFFSET:   r_cfg.horizontal_offset <= i_cfg_data[OFFSET_W-1:0];
                CFG_V_OFFSET:   r_cfg.vertical_offset   <= i_cfg_data[OFFSET_W-1:0];
                CFG_COLUMNS:    r_cfg.columns_per_row   <= i_cfg_data[CURSOR_W-1:0];
                CFG_ROWS:       r_cfg.rows_per_screen   <= i_cfg_data[CURSOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    tcgr_front #(
        .CELL_WIDTH  (CELL_WIDTH),
        .CELL_HEIGHT (CELL_HEIGHT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_kind       (i_kind),
        .i_char_code  (i_char_code),
        .i_new_column (i_new_column),
        .i_new_row    (i_new_row),
        .i_cfg        (r_cfg),
        .o_q_wr       (w_q_wr),
        .o_q_cmd      (w_q_wr_cmd)
    );

    tcgr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_q_wr),
        .i_cmd   (w_q_wr_cmd),
        .o_full  (w_q_full),
        .i_rd    (w_q_rd),
        .o_cmd   (w_q_rd_cmd),
        .o_empty (w_q_empty)
    );

    tcgr_back #(
        .GLYPH_ROWS (GLYPH_ROWS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_cmd       (w_q_rd_cmd),
        .i_q_empty     (w_q_empty),
        .o_q_rd        (w_q_rd),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_last_pixel  (o_last_pixel)
    );

    `TCGR_ASSERT_ALWAYS(a_no_write_when_full, !(w_q_wr && w_q_full), "queue written while full")
    `TCGR_ASSERT_ALWAYS(a_no_read_when_empty, !(w_q_rd && w_q_empty), "queue read while empty")
    `TCGR_ASSERT_NEXT(a_write_fills, w_q_wr && w_q_empty, !w_q_empty, "queued draw lost")

endmodule
`default_nettype wire

### sim/tb_text_cursor_glyph_renderer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text cursor glyph renderer - testbench
// Feeds draw and set-cursor transactions through the push/full queue port and
// checks every pixel transaction popped from the output against an in-bench
// font and cursor tracker. Runs a short directed table under reset settings,
// then random traffic across several register settings, including extremes
// and zero wrap counts, with random idle cycles on both sides.
// ----------------------------------------------------------------------------
module tb_text_cursor_glyph_renderer_top;
    import tcgr_pkg::*;

    localparam int GLYPH_W      = 5;
    localparam int GLYPH_H      = 7;
    localparam int CELL_W       = 6;
    localparam int CELL_H       = 8;
    localparam int PRINTABLE_LO = 32;
    localparam int PRINTABLE_HI = 127;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 54;
    localparam int DIRECTED_ROWS = 24;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COLOR_W-1:0] color;
        logic               last;
    } t_pixel;

    typedef struct packed {
        logic                kind;
        logic [CODE_W-1:0]   code;
        logic [CURSOR_W-1:0] column;
        logic [CURSOR_W-1:0] row;
        logic                typed;
        logic [COORD_W-1:0]  x0;
        logic [COORD_W-1:0]  y0;
        logic [COLOR_W-1:0]  fill;
    } t_stim;

    localparam logic [39:0] FONT_5X7 [0:95] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
        40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
        40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
        40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h081454543C,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h007F102844,
        40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
        40'h00007F0000, 40'h0041360800, 40'h08082A1C08, 40'h081C2A0808
    };

    // kind, code, column, row, typed, first x, first y, fill colour
    localparam t_stim DIRECTED [0:DIRECTED_ROWS-1] = '{
        '{KIND_DRAW,   8'h20, 6'd0,  6'd0,  1'b1, 10'd0,   10'd0,   16'h0000},
        '{KIND_DRAW,   8'h00, 6'd0,  6'd0,  1'b1, 10'd6,   10'd0,   16'h0000},
        '{KIND_DRAW,   8'hFF, 6'd0,  6'd0,  1'b1, 10'd12,  10'd0,   16'h0000},
        '{KIND_DRAW,   8'h1F, 6'd0,  6'd0,  1'b1, 10'd18,  10'd0,   16'h0000},
        '{KIND_DRAW,   8'h80, 6'd0,  6'd0,  1'b1, 10'd24,  10'd0,   16'h0000},
        '{KIND_DRAW,   8'h30, 6'd0,  6'd0,  1'b0, 10'd0,   10'd0,   16'h0000},
        '{KIND_DRAW,   8'h7F, 6'd0,  6'd0,  1'b0, 10'd0,   10'd0,   16'h0000},
        '{KIND_DRAW,   8'h21, 6'd0,  6'd0,  1'b0, 10'd0,   10'd0,   16'h0000},
        '{KIND_DRAW,   8'h41, 6'd0,  6'd0,  1'b0, 10'd0,   10'd0,   16'h0000},
        '{KIND_CURSOR, 8'hFF, 6'd20, 6'd19, 1'b0, 10'd0,   10'd0,   16'h0000},
        '{KIND_DRAW,   8'h23, 6'd0,  6'd0,  1'b0, 10'd0,   10'd0,   16'h0000},
        '{KIND_DRAW,   8'h20, 6'd0,  6'd0,  1'b1, 10'd0,   10'd0,   16'h0000},
        '{KIND_CURSOR, 8'h00, 6'd63, 6'd63, 1'b0, 10'd0,   10'd0,   16'h0000},
        '{KIND_DRAW,   8'h20, 6'd0,  6'd0,  1'b1, 10'd378, 10'd504, 16'h0000},
        '{KIND_CURSOR, 8'h7F, 6'd5,  6'd45, 1'b0, 10'd0,   10'd0,   16'h0000},
        '{KIND_DRAW,   8'h5F, 6'd0,  6'd0,  1'b0, 10'd0,   10'd0,   16'h0000},
        '{KIND_DRAW,   8'h20, 6'd0,  6'd0,  1'b1, 10'd36,  10'd0,   16'h0000},
        '{KIND_CURSOR, 8'hAA, 6'd20, 6'd0,  1'b0, 10'd0,   10'd0,   16'h0000},
        '{KIND_DRAW,   8'h7E, 6'd0,  6'd0,  1'b0, 10'd0,   10'd0,   16'h0000},
        '{KIND_DRAW,   8'h7B, 6'd0,  6'd0,  1'b0, 10'd0,   10'd0,   16'h0000},
        '{KIND_DRAW,   8'h00, 6'd0,  6'd0,  1'b1, 10'd6,   10'd8,   16'h0000},
        '{KIND_CURSOR, 8'h55, 6'd42, 6'd21, 1'b0, 10'd0,   10'd0,   16'h0000},
        '{KIND_DRAW,   8'h40, 6'd0,  6'd0,  1'b0, 10'd0,   10'd0,   16'h0000},
        '{KIND_DRAW,   8'h20, 6'd0,  6'd0,  1'b1, 10'd0,   10'd0,   16'h0000}
    };

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  push          = 1'b0;
    logic                  full;
    logic                  i_kind        = 1'b0;
    logic [CODE_W-1:0]     i_char_code   = '0;
    logic [CURSOR_W-1:0]   i_new_column  = '0;
    logic [CURSOR_W-1:0]   i_new_row     = '0;
    logic                  empty;
    logic                  pop           = 1'b0;
    logic [COORD_W-1:0]    o_pixel_x;
    logic [COORD_W-1:0]    o_pixel_y;
    logic [COLOR_W-1:0]    o_pixel_color;
    logic                  o_last_pixel;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    logic [COLOR_W-1:0]  fg_color      = 16'hFFFF;
    logic [COLOR_W-1:0]  bg_color      = 16'h0000;
    logic [7:0]          h_offset      = 8'd0;
    logic [7:0]          v_offset      = 8'd0;
    logic [CURSOR_W-1:0] cols_per_row  = 6'd21;
    logic [CURSOR_W-1:0] rows_per_scrn = 6'd20;
    logic [CURSOR_W-1:0] cursor_col    = '0;
    logic [CURSOR_W-1:0] cursor_row    = '0;

    t_pixel pending_pixels [$];
    int     mismatches = 0;
    logic   send_burst = 1'b0;
    logic   pop_burst  = 1'b0;

    text_cursor_glyph_renderer_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_kind        (i_kind),
        .i_char_code   (i_char_code),
        .i_new_column  (i_new_column),
        .i_new_row     (i_new_row),
        .empty         (empty),
        .pop           (pop),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_last_pixel  (o_last_pixel),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic queue_glyph(input int base_x, input int base_y, input logic [39:0] glyph,
                               input logic [COLOR_W-1:0] on_color,
                               input logic [COLOR_W-1:0] off_color);
        t_pixel     px;
        logic [7:0] column_bits;
        for (int gr = 0; gr < GLYPH_H; gr++) begin
            for (int gc = 0; gc < GLYPH_W; gc++) begin
                column_bits = glyph[39 - 8*gc -: 8];
                px.x = COORD_W'(base_x + gc);
                px.y = COORD_W'(base_y + gr);
                px.color = column_bits[gr] ? on_color : off_color;
                px.last = (gr == GLYPH_H - 1) && (gc == GLYPH_W - 1);
                pending_pixels.push_back(px);
            end
        end
    endtask

    task automatic apply_command(input t_stim it);
        int slot;
        int next_col;
        int next_row;
        if (it.kind == KIND_CURSOR) begin
            cursor_col = it.column;
            cursor_row = it.row;
        end else begin
            if (it.typed) begin
                queue_glyph(int'(it.x0), int'(it.y0), 40'h0, '0, it.fill);
            end else begin
                slot = (it.code >= PRINTABLE_LO && it.code <= PRINTABLE_HI) ?
                       int'(it.code) - PRINTABLE_LO : 0;
                queue_glyph(int'(cursor_col) * CELL_W + int'(h_offset),
                            int'(cursor_row) * CELL_H + int'(v_offset),
                            FONT_5X7[slot], fg_color, bg_color);
            end
            next_col = int'(cursor_col) + 1;
            next_row = int'(cursor_row);
            if (next_col >= int'(cols_per_row)) begin
                next_col = 0;
                next_row = next_row + 1;
            end
            if (next_row >= int'(rows_per_scrn)) begin
                next_row = 0;
            end
            cursor_col = CURSOR_W'(next_col);
            cursor_row = CURSOR_W'(next_row);
        end
    endtask

    task automatic send_item(input t_stim it);
        int gap;
        if ($urandom_range(0, 15) == 0) begin
            send_burst = !send_burst;
        end
        gap = send_burst ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push         <= 1'b1;
        i_kind       <= it.kind;
        i_char_code  <= it.code;
        i_new_column <= it.column;
        i_new_row    <= it.row;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        apply_command(it);
    endtask

    task automatic wait_for_drain();
        push <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_FOREGROUND: fg_color      = data;
            CFG_BACKGROUND: bg_color      = data;
            CFG_H_OFFSET:   h_offset      = data[7:0];
            CFG_V_OFFSET:   v_offset      = data[7:0];
            CFG_COLUMNS:    cols_per_row  = data[CURSOR_W-1:0];
            CFG_ROWS:       rows_per_scrn = data[CURSOR_W-1:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // unused upper data bits carry junk
    task automatic apply_settings(input logic [15:0] fg, input logic [15:0] bg,
                                  input logic [7:0] hoff, input logic [7:0] voff,
                                  input logic [5:0] cols, input logic [5:0] rows);
        write_reg(CFG_FOREGROUND, fg);
        write_reg(CFG_BACKGROUND, bg);
        write_reg(CFG_H_OFFSET, {8'($urandom), hoff});
        write_reg(CFG_V_OFFSET, {8'($urandom), voff});
        write_reg(CFG_COLUMNS, {10'($urandom), cols});
        write_reg(CFG_ROWS, {10'($urandom), rows});
    endtask

    function automatic t_stim random_item();
        t_stim it;
        it = '0;
        it.kind = ($urandom_range(0, 4) == 0) ? KIND_CURSOR : KIND_DRAW;
        if ($urandom_range(0, 3) == 0) begin
            it.code = CODE_W'($urandom_range(0, 255));
        end else begin
            it.code = CODE_W'($urandom_range(PRINTABLE_LO, PRINTABLE_HI));
        end
        if ($urandom_range(0, 3) == 0) begin
            it.column = CURSOR_W'($urandom_range(0, 63));
            it.row    = CURSOR_W'($urandom_range(0, 63));
        end else begin
            it.column = CURSOR_W'($urandom_range(0, cols_per_row == 0 ? 0 : cols_per_row - 1));
            it.row    = CURSOR_W'($urandom_range(0, rows_per_scrn == 0 ? 0 : rows_per_scrn - 1));
        end
        return it;
    endfunction

    task automatic check_pixel();
        t_pixel want;
        if (pending_pixels.size() == 0) begin
            $display("%0t: pixel expected none, got x=%0d y=%0d color=%h last=%b",
                     $time, o_pixel_x, o_pixel_y, o_pixel_color, o_last_pixel);
            mismatches++;
        end else begin
            want = pending_pixels.pop_front();
            if (o_pixel_x !== want.x) begin
                $display("%0t: pixel_x expected %0d, got %0d", $time, want.x, o_pixel_x);
                mismatches++;
            end
            if (o_pixel_y !== want.y) begin
                $display("%0t: pixel_y expected %0d, got %0d", $time, want.y, o_pixel_y);
                mismatches++;
            end
            if (o_pixel_color !== want.color) begin
                $display("%0t: pixel_color expected %h, got %h", $time, want.color,
                         o_pixel_color);
                mismatches++;
            end
            if (o_last_pixel !== want.last) begin
                $display("%0t: last_pixel expected %b, got %b", $time, want.last,
                         o_last_pixel);
                mismatches++;
            end
        end
    endtask

    initial begin
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 63) == 0) begin
                pop_burst = !pop_burst;
            end
            stall = pop_burst ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            check_pixel();
        end
    end

    initial begin
        int guard;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            send_item(DIRECTED[i]);
        end

        for (int phase = 1; phase <= PHASES; phase++) begin
            wait_for_drain();
            case (phase)
                1: apply_settings(16'h0000, 16'hFFFF, 8'd255, 8'd255, 6'd63, 6'd63);
                2: apply_settings(16'($urandom), 16'($urandom), 8'd0, 8'd0, 6'd1, 6'd1);
                3: apply_settings(16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                                  6'd0, 6'd0);
                default: apply_settings(16'($urandom), 16'($urandom), 8'($urandom),
                                        8'($urandom), 6'($urandom_range(1, 63)),
                                        6'($urandom_range(1, 63)));
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2 || $urandom_range(0, 39) == 0) begin
                    wait_for_drain();
                end
                send_item(random_item());
            end
        end

        push <= 1'b0;
        guard = 0;
        while (pending_pixels.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (50) @(posedge i_clk);
        if (pending_pixels.size() != 0) begin
            $display("%0t: %0d pixels expected, none arrived", $time, pending_pixels.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
